FILE: rtl/core/hq_pkg.sv
package hq_pkg;

    localparam int CAPACITY     = 1024;
    localparam int KEY_BITS     = 24;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int UPC_W        = 4;
    localparam int OP_W         = 4;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // microprogram addresses
    localparam logic [UPC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] S_PUSH     = 4'd2;
    localparam logic [UPC_W-1:0] S_UP_RD    = 4'd3;
    localparam logic [UPC_W-1:0] S_UP_CMP   = 4'd4;
    localparam logic [UPC_W-1:0] S_PUSH_FIN = 4'd5;
    localparam logic [UPC_W-1:0] S_POP      = 4'd6;
    localparam logic [UPC_W-1:0] S_POP_TAKE = 4'd7;
    localparam logic [UPC_W-1:0] S_DN_RD    = 4'd8;
    localparam logic [UPC_W-1:0] S_DN_CMP   = 4'd9;
    localparam logic [UPC_W-1:0] S_POP_FIN  = 4'd10;
    localparam logic [UPC_W-1:0] S_FULL     = 4'd11;
    localparam logic [UPC_W-1:0] S_EMPTY    = 4'd12;

    // jump conditions
    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_START = 4'd2;
    localparam logic [3:0] C_IS_POP   = 4'd3;
    localparam logic [3:0] C_FULL     = 4'd4;
    localparam logic [3:0] C_AT_ROOT  = 4'd5;
    localparam logic [3:0] C_UP_LESS  = 4'd6;
    localparam logic [3:0] C_EMPTY    = 4'd7;
    localparam logic [3:0] C_NO_LEFT  = 4'd8;
    localparam logic [3:0] C_DN_GO    = 4'd9;

    // datapath operations
    localparam logic [OP_W-1:0] A_NONE      = 4'd0;
    localparam logic [OP_W-1:0] A_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] A_PUSH_INIT = 4'd2;
    localparam logic [OP_W-1:0] A_RD_PARENT = 4'd3;
    localparam logic [OP_W-1:0] A_UP_STEP   = 4'd4;
    localparam logic [OP_W-1:0] A_PUSH_DONE = 4'd5;
    localparam logic [OP_W-1:0] A_RD_POP    = 4'd6;
    localparam logic [OP_W-1:0] A_POP_TAKE  = 4'd7;
    localparam logic [OP_W-1:0] A_RD_KIDS   = 4'd8;
    localparam logic [OP_W-1:0] A_DN_STEP   = 4'd9;
    localparam logic [OP_W-1:0] A_POP_DONE  = 4'd10;
    localparam logic [OP_W-1:0] A_FLAG_FULL = 4'd11;
    localparam logic [OP_W-1:0] A_FLAG_EMPT = 4'd12;

    typedef struct packed {
        logic                    req_type;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [1:0]              status;
        logic                    is_empty;
        logic [CNT_W-1:0]        occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic at_root;
        logic up_less;
        logic no_left;
        logic dn_go;
    } flags_t;

    // control store: op, jump condition, jump target (else fall through)
    function automatic uword_t uc_rom(input logic [UPC_W-1:0] upc);
        uword_t w;
        case (upc)
            S_IDLE:     w = '{A_LOAD,      C_NO_START, S_IDLE};
            S_DISPATCH: w = '{A_NONE,      C_IS_POP,   S_POP};
            S_PUSH:     w = '{A_PUSH_INIT, C_FULL,     S_FULL};
            S_UP_RD:    w = '{A_RD_PARENT, C_AT_ROOT,  S_PUSH_FIN};
            S_UP_CMP:   w = '{A_UP_STEP,   C_UP_LESS,  S_UP_RD};
            S_PUSH_FIN: w = '{A_PUSH_DONE, C_ALWAYS,   S_IDLE};
            S_POP:      w = '{A_RD_POP,    C_EMPTY,    S_EMPTY};
            S_POP_TAKE: w = '{A_POP_TAKE,  C_NEVER,    S_IDLE};
            S_DN_RD:    w = '{A_RD_KIDS,   C_NO_LEFT,  S_POP_FIN};
            S_DN_CMP:   w = '{A_DN_STEP,   C_DN_GO,    S_DN_RD};
            S_POP_FIN:  w = '{A_POP_DONE,  C_ALWAYS,   S_IDLE};
            S_FULL:     w = '{A_FLAG_FULL, C_ALWAYS,   S_IDLE};
            S_EMPTY:    w = '{A_FLAG_EMPT, C_ALWAYS,   S_IDLE};
            default:    w = '{A_NONE,      C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/hq_seq.sv
module hq_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  hq_pkg::flags_t          flags,
    output logic [hq_pkg::OP_W-1:0] op,
    output logic                    busy
);
    import hq_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uw;
    logic             take;

    assign uw   = uc_rom(upc_reg);
    assign op   = uw.op;
    assign busy = (upc_reg != S_IDLE);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !start;
            C_IS_POP:   take = flags.is_pop;
            C_FULL:     take = flags.full;
            C_AT_ROOT:  take = flags.at_root;
            C_UP_LESS:  take = flags.up_less;
            C_EMPTY:    take = flags.empty;
            C_NO_LEFT:  take = flags.no_left;
            C_DN_GO:    take = flags.dn_go;
            default:    take = 1'b1;
        endcase
        upc_next = take ? uw.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_IDLE;
        else
            upc_reg <= upc_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (upc_reg == S_DISPATCH))
        else $error("accepted request did not enter dispatch");

    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!start && !busy) |=> !busy)
        else $error("sequencer left idle without a request");

endmodule

FILE: rtl/core/hq_dp.sv
module hq_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [hq_pkg::OP_W-1:0] op,
    input  hq_pkg::req_t            req,
    output hq_pkg::flags_t          flags,
    output hq_pkg::rsp_t            result,
    output logic                    done
);
    import hq_pkg::*;

    localparam int WIDE_W = IDX_W + 2;

    entry_t           heap_mem [CAPACITY];

    req_t             req_reg, req_next;
    entry_t           ent_reg, ent_next;
    entry_t           ret_reg, ret_next;
    entry_t           rda_reg, rdb_reg;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsp_t             res_reg, res_next;
    logic             done_reg, done_next;

    logic             we;
    logic [IDX_W-1:0] wa, ra, rb;
    entry_t           wd;

    logic [IDX_W-1:0]  parent_idx;
    logic [WIDE_W-1:0] left_w, right_w, cnt_w;
    logic              right_missing, pick_right;
    entry_t            child;
    logic [IDX_W-1:0]  child_idx;

    assign parent_idx    = (cur_reg - IDX_W'(1)) >> 1;
    assign left_w        = {1'b0, cur_reg, 1'b1};
    assign right_w       = left_w + WIDE_W'(1);
    assign cnt_w         = WIDE_W'(cnt_reg);
    assign right_missing = (right_w >= cnt_w);
    // right child wins a tie
    assign pick_right    = !right_missing && !(rda_reg.key < rdb_reg.key);
    assign child         = pick_right ? rdb_reg : rda_reg;
    assign child_idx     = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

    assign flags.is_pop  = (req_reg.req_type == REQ_POP);
    assign flags.full    = (cnt_reg == CNT_W'(CAPACITY));
    assign flags.empty   = (cnt_reg == '0);
    assign flags.at_root = (cur_reg == '0);
    assign flags.up_less = (ent_reg.key < rda_reg.key);
    assign flags.no_left = (left_w >= cnt_w);
    assign flags.dn_go   = (ent_reg.key > child.key);

    assign result = res_reg;
    assign done   = done_reg;

    always_comb
    begin
        req_next  = req_reg;
        ent_next  = ent_reg;
        ret_next  = ret_reg;
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        we        = 1'b0;
        wa        = cur_reg;
        wd        = ent_reg;
        ra        = parent_idx;
        rb        = right_w[IDX_W-1:0];
        case (op)
            A_NONE: ;
            A_LOAD:
                req_next = req;
            A_PUSH_INIT:
            begin
                cur_next = cnt_reg[IDX_W-1:0];
                ent_next = '{req_reg.key, req_reg.payload};
            end
            A_RD_PARENT:
                ra = parent_idx;
            A_UP_STEP:
            begin
                // hole moves up: parent drops into the hole, else the carried entry fills it
                we = 1'b1;
                wd = flags.up_less ? rda_reg : ent_reg;
                if (flags.up_less)
                    cur_next = parent_idx;
            end
            A_PUSH_DONE:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                res_next = '{'0, '0, ST_OK, 1'b0, cnt_reg + CNT_W'(1)};
                done_next = 1'b1;
            end
            A_RD_POP:
            begin
                ra = '0;
                rb = IDX_W'(cnt_reg - CNT_W'(1));
            end
            A_POP_TAKE:
            begin
                ret_next = rda_reg;
                ent_next = rdb_reg;
                cnt_next = cnt_reg - CNT_W'(1);
                cur_next = '0;
            end
            A_RD_KIDS:
            begin
                ra = left_w[IDX_W-1:0];
                rb = right_w[IDX_W-1:0];
            end
            A_DN_STEP:
            begin
                we = 1'b1;
                wd = flags.dn_go ? child : ent_reg;
                if (flags.dn_go)
                    cur_next = child_idx;
            end
            A_POP_DONE:
            begin
                we        = 1'b1;
                res_next  = '{ret_reg.key, ret_reg.payload, ST_OK,
                              flags.empty, cnt_reg};
                done_next = 1'b1;
            end
            A_FLAG_FULL:
            begin
                res_next  = '{'0, '0, ST_FULL, flags.empty, cnt_reg};
                done_next = 1'b1;
            end
            A_FLAG_EMPT:
            begin
                res_next  = '{'0, '0, ST_EMPTY, flags.empty, cnt_reg};
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[wa] <= wd;
        rda_reg <= heap_mem[ra];
        rdb_reg <= heap_mem[rb];
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        ent_reg <= ent_next;
        ret_reg <= ret_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cnt_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == $past(cnt_reg) + CNT_W'(1) ||
             cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count jumped");

endmodule

FILE: rtl/core/binary_min_heap_queue.sv
// Channel   Handshake              Payload            Notes
// request   start / busy           req    (req_t)     taken when start && !busy
// result    done (1-cycle strobe)  result (rsp_t)     one result per request
//
// A flagged request goes straight to its flag step. A push climbs and a pop
// descends level by level until a key compare or the tree bounds stop it; a
// level is one registered memory read step and one compare/write step of the
// microprogram. Reset clears the count, strobe and sequencer, not the heap
// memory. busy drops as done shows, so the next request may go in then; the
// receiver cannot stall.
module binary_min_heap_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  hq_pkg::req_t  req,
    output logic          busy,
    output logic          done,
    output hq_pkg::rsp_t  result
);
    import hq_pkg::*;

    // control word op code from the microprogram ROM to the datapath
    logic [OP_W-1:0] op;
    // datapath status used for conditional jumps
    flags_t          flags;

    // sequencer: step counter plus control store
    hq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .op    (op),
        .busy  (busy)
    );

    // datapath: heap memory, carried entry, hole index, count, result register
    hq_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .req    (req),
        .flags  (flags),
        .result (result),
        .done   (done)
    );

    // result transfer always lands with the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // empty flag agrees with the occupancy reported
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    // a flagged request returns no entry
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.out_key == '0 && result.out_payload == '0))
        else $error("flagged request returned data");

endmodule

FILE: tb/tb.sv
module tb;
    import hq_pkg::*;

    // Shadow copy of the heap: mirrors every accepted request and keeps the
    // responses the block owes, oldest first.
    class heap_shadow;
        entry_t      slots [CAPACITY];
        int unsigned entries;
        rsp_t        owed_rsp [$];
        int unsigned mismatches;

        function new();
            entries    = 0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return owed_rsp.size();
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            entry_t tmp;
            tmp      = slots[a];
            slots[a] = slots[b];
            slots[b] = tmp;
        endfunction

        // Work out the response for one accepted request and update the copy.
        function void note_request(req_t r);
            rsp_t        exp;
            int unsigned cur;
            int unsigned parent;
            int unsigned left;
            int unsigned right;
            int unsigned child;
            exp = '0;
            exp.status = ST_OK;
            if (r.req_type == REQ_PUSH)
            begin
                if (entries >= CAPACITY)
                    exp.status = ST_FULL;
                else
                begin
                    slots[entries].key     = r.key;
                    slots[entries].payload = r.payload;
                    cur = entries;
                    entries++;
                    // climb only while strictly below the parent
                    while (cur > 0)
                    begin
                        parent = (cur - 1) / 2;
                        if (!(slots[cur].key < slots[parent].key))
                            break;
                        swap_slots(cur, parent);
                        cur = parent;
                    end
                end
            end
            else
            begin
                if (entries == 0)
                    exp.status = ST_EMPTY;
                else
                begin
                    exp.out_key     = slots[0].key;
                    exp.out_payload = slots[0].payload;
                    entries--;
                    slots[0] = slots[entries];
                    cur = 0;
                    while (cur * 2 + 1 < entries)
                    begin
                        left  = cur * 2 + 1;
                        right = cur * 2 + 2;
                        // right child wins a tie
                        if (right >= entries)
                            child = left;
                        else
                            child = (slots[left].key < slots[right].key) ? left : right;
                        if (slots[cur].key <= slots[child].key)
                            break;
                        swap_slots(cur, child);
                        cur = child;
                    end
                end
            end
            exp.is_empty  = (entries == 0);
            exp.occupancy = entries[CNT_W-1:0];
            owed_rsp.push_back(exp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (owed_rsp.size() == 0)
            begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result key=%h payload=%h status=%0d",
                             got.out_key, got.out_payload, got.status);
                mismatches++;
                return;
            end
            exp = owed_rsp.pop_front();
            if (got.out_key !== exp.out_key || got.out_payload !== exp.out_payload ||
                got.status !== exp.status || got.is_empty !== exp.is_empty ||
                got.occupancy !== exp.occupancy)
            begin
                if (mismatches < 10)
                begin
                    $write("ERROR: result mismatch exp key=%h pl=%h st=%0d emp=%b occ=%0d",
                           exp.out_key, exp.out_payload, exp.status, exp.is_empty,
                           exp.occupancy);
                    $display(" got key=%h pl=%h st=%0d emp=%b occ=%0d",
                             got.out_key, got.out_payload, got.status,
                             got.is_empty, got.occupancy);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t result;

    heap_shadow shadow = new();

    // when low, requests go back to back with no idle cycles between them
    bit idle_on = 1'b1;

    binary_min_heap_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Results come as one-cycle strobes that cannot be held off; sample the
    // pre-edge values at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result(result);
    end

    function automatic req_t make_req(logic kind, logic [KEY_BITS-1:0] k,
                                      logic [PAYLOAD_BITS-1:0] p);
        req_t r;
        r.req_type = kind;
        r.key      = k;
        r.payload  = p;
        return r;
    endfunction

    // Keys mix full-range values with extremes and a narrow band, so equal
    // keys (and the right-child tie rule) come up often.
    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_BITS'($urandom_range(0, 7));
            4:       return KEY_BITS'($urandom_range(0, 255));
            default: return raw[KEY_BITS-1:0];
        endcase
    endfunction

    function automatic req_t random_req(int unsigned push_pct);
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(1, 100) <= push_pct)
            return make_req(REQ_PUSH, pick_key(), raw[PAYLOAD_BITS-1:0]);
        // pops carry junk in the ignored fields
        return make_req(REQ_POP, pick_key(), raw[PAYLOAD_BITS-1:0]);
    endfunction

    // Mostly no gap, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Hold the request up until the block takes it (start high, busy low at
    // the edge), then optionally go idle with junk on the request bus.
    task automatic transfer(input req_t r);
        int unsigned gap;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        shadow.note_request(r);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            req   <= random_req(50);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for the block to catch up; always lets at least
    // one edge pass so start is never lowered and raised in one step.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (shadow.outstanding() != 0);
    endtask

    initial
    begin
        int unsigned push_pct;
        int unsigned n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on empty, extreme and alternating fields, equal keys
        // that force tie handling on the way down, then pop past empty.
        transfer(make_req(REQ_POP, '1, '1));
        transfer(make_req(REQ_PUSH, '0, '0));
        transfer(make_req(REQ_PUSH, '1, '1));
        transfer(make_req(REQ_PUSH, 24'h555555, 16'hAAAA));
        transfer(make_req(REQ_PUSH, 24'hAAAAAA, 16'h5555));
        transfer(make_req(REQ_PUSH, 24'd5, 16'd1));
        transfer(make_req(REQ_PUSH, 24'd5, 16'd2));
        transfer(make_req(REQ_PUSH, 24'd5, 16'd3));
        transfer(make_req(REQ_PUSH, '0, 16'hFFFF));
        repeat (9) transfer(make_req(REQ_POP, '0, '0));

        // Small heap: push/pop bias flips every 25 transfers so the heap
        // keeps running dry and refilling.
        push_pct = 70;
        for (n = 0; n < 150; n++)
        begin
            if (n % 25 == 0)
            begin
                push_pct = (push_pct == 70) ? 30 : 70;
                idle_on  = ($urandom_range(0, 3) != 0);
            end
            transfer(random_req(push_pct));
        end
        idle_on = 1'b1;
        wait_drained();

        // Fill to capacity; deep sift-ups near the end. Each run of 40 requests
        // goes back to back or not by a random coin toss.
        n = 0;
        while (shadow.entries < CAPACITY)
        begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 1) != 0);
            transfer(random_req(100));
            n++;
        end
        repeat (4) transfer(random_req(100));

        // Churn around full: deep sift-downs and pushes on a full heap.
        for (n = 0; n < 250; n++)
        begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            transfer(random_req(50));
            if ($urandom_range(0, 99) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("binary_min_heap_queue verification clean");
        else
            $display("binary_min_heap_queue verification failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5000000;
        $display("binary_min_heap_queue verification failed");
        $finish;
    end

endmodule
